// ===== sv/pbb_pkg.sv =====
// ----------------------------------------------------------------------------
// pbb_pkg: shared types and constants of the path bounding box block
// Command and status words between controller and datapath, path command
// codes and the fixed parameters of the curve evaluation.
// ----------------------------------------------------------------------------
package pbb_pkg;

  // Fraction bits of the curve parameter t.
  localparam int T_BITS = 15;

  // De Casteljau schedule on a four-entry shift line: a set bit is a drop
  // step, a clear bit a lerp of the two front entries.
  localparam int LERP_STEPS = 9;
  localparam logic [LERP_STEPS-1:0] DROP_MASK = 9'b011001000;

  typedef enum logic [1:0] {
    MODE_MOVE  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_CUBIC = 2'd2,
    MODE_SKIP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ROOT_LIN,
    ROOT_MINUS,
    ROOT_PLUS
  } root_sel_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_BASE,
    CMD_COEF,
    CMD_MUL_BB,
    CMD_MUL_AC,
    CMD_MUL_STEP,
    CMD_DISC,
    CMD_SQRT_STEP,
    CMD_ROOT,
    CMD_DIV_STEP,
    CMD_LOAD_X,
    CMD_LOAD_Y,
    CMD_LMUL,
    CMD_LADD,
    CMD_LDROP,
    CMD_INC,
    CMD_AXIS_NEXT,
    CMD_EMIT
  } cmd_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BASE,
    S_COEF,
    S_CLASS,
    S_MUL1,
    S_MULAC,
    S_MUL2,
    S_DISC,
    S_SQRT,
    S_ROOT,
    S_DIV,
    S_LOADX,
    S_LMUL,
    S_LADD,
    S_LOADY,
    S_INC,
    S_RNEXT,
    S_AXIS,
    S_FIN
  } state_t;

  typedef struct packed {
    cmd_op_t   op;
    root_sel_t sel;
  } pbb_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  last;
    logic  flat_a;
    logic  flat_b;
    logic  disc_neg;
    logic  root_ok;
    logic  cnt_done;
    logic  drop;
    logic  lerp_last;
    logic  axis;
    logic  out_busy;
  } pbb_stat_t;

endpackage

// ===== sv/pbb_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbb_ctrl: sequencer of the path bounding box block
// Steps the datapath through loading, the derivative solve of each axis,
// the root divisions, curve evaluation and the final box word.
// ----------------------------------------------------------------------------
module pbb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pbb_pkg::pbb_stat_t stat,
  output pbb_pkg::pbb_cmd_t  cmd
);
  import pbb_pkg::*;

  state_t    state, state_next;
  root_sel_t root_sel, root_sel_next;
  logic      ev_y, ev_y_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      root_sel <= ROOT_LIN;
      ev_y     <= 1'b0;
    end else begin
      state    <= state_next;
      root_sel <= root_sel_next;
      ev_y     <= ev_y_next;
    end
  end

  always_comb begin
    state_next    = state;
    root_sel_next = root_sel;
    ev_y_next     = ev_y;
    cmd.op        = CMD_NONE;
    cmd.sel       = root_sel;
    in_ready      = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = CMD_LOAD;
          state_next = S_BASE;
        end
      end
      S_BASE: begin
        cmd.op     = CMD_BASE;
        state_next = (stat.mode == MODE_CUBIC) ? S_COEF : S_FIN;
      end
      S_COEF: begin
        cmd.op     = CMD_COEF;
        state_next = S_CLASS;
      end
      S_CLASS: begin
        if (stat.flat_a) begin
          if (stat.flat_b) begin
            state_next = S_AXIS;
          end else begin
            root_sel_next = ROOT_LIN;
            state_next    = S_ROOT;
          end
        end else begin
          cmd.op     = CMD_MUL_BB;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.op = CMD_MUL_STEP;
        if (stat.cnt_done) state_next = S_MULAC;
      end
      S_MULAC: begin
        cmd.op     = CMD_MUL_AC;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.op = CMD_MUL_STEP;
        if (stat.cnt_done) state_next = S_DISC;
      end
      S_DISC: begin
        cmd.op     = CMD_DISC;
        state_next = stat.disc_neg ? S_AXIS : S_SQRT;
      end
      S_SQRT: begin
        cmd.op = CMD_SQRT_STEP;
        if (stat.cnt_done) begin
          root_sel_next = ROOT_MINUS;
          state_next    = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.op     = CMD_ROOT;
        state_next = stat.root_ok ? S_DIV : S_RNEXT;
      end
      S_DIV: begin
        cmd.op = CMD_DIV_STEP;
        if (stat.cnt_done) state_next = S_LOADX;
      end
      S_LOADX: begin
        cmd.op     = CMD_LOAD_X;
        ev_y_next  = 1'b0;
        state_next = S_LMUL;
      end
      S_LMUL: begin
        if (stat.drop) begin
          cmd.op = CMD_LDROP;
        end else begin
          cmd.op     = CMD_LMUL;
          state_next = S_LADD;
        end
      end
      S_LADD: begin
        cmd.op = CMD_LADD;
        if (stat.lerp_last) state_next = ev_y ? S_INC : S_LOADY;
        else state_next = S_LMUL;
      end
      S_LOADY: begin
        cmd.op     = CMD_LOAD_Y;
        ev_y_next  = 1'b1;
        state_next = S_LMUL;
      end
      S_INC: begin
        cmd.op     = CMD_INC;
        state_next = S_RNEXT;
      end
      S_RNEXT: begin
        if (root_sel == ROOT_MINUS) begin
          root_sel_next = ROOT_PLUS;
          state_next    = S_ROOT;
        end else begin
          state_next = S_AXIS;
        end
      end
      S_AXIS: begin
        if (!stat.axis) begin
          cmd.op     = CMD_AXIS_NEXT;
          state_next = S_COEF;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!stat.last) begin
          state_next = S_IDLE;
        end else if (!stat.out_busy) begin
          cmd.op     = CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/pbb_datapath.sv =====
// ----------------------------------------------------------------------------
// pbb_datapath: arithmetic and state of the path bounding box block
// Running box and pen, bit-serial multiplier, square root and divider,
// a shared lerp unit and the output register.
// ----------------------------------------------------------------------------
module pbb_datapath #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pbb_pkg::pbb_cmd_t      cmd,
  output pbb_pkg::pbb_stat_t     stat,
  input  pbb_pkg::mode_t         in_mode,
  input  logic signed [CW-1:0]   in_fx,
  input  logic signed [CW-1:0]   in_fy,
  input  logic signed [CW-1:0]   in_sx,
  input  logic signed [CW-1:0]   in_sy,
  input  logic signed [CW-1:0]   in_ex,
  input  logic signed [CW-1:0]   in_ey,
  input  logic                   in_last,
  input  logic                   cfg_valid,
  input  logic [FB:0]            cfg_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   out_box_valid,
  output logic [CW-1:0]          out_left,
  output logic [CW-1:0]          out_top,
  output logic [CW-1:0]          out_width,
  output logic [CW-1:0]          out_height
);
  import pbb_pkg::*;

  localparam int AW   = CW + 4;
  localparam int MW   = CW + 3;
  localparam int PW   = 2 * MW;
  localparam int DW   = PW + 1;
  localparam int SW   = MW + 1;
  localparam int RW   = SW + 2;
  localparam int NW   = AW + 1;
  localparam int EW   = FB + 1;
  localparam int LW   = CW + 1;
  localparam int LPW  = LW + T_BITS + 1;
  localparam int CNTW = $clog2(SW + 1);
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [LPW-1:0] HALF = LPW'(1) <<< (T_BITS - 1);

  logic [EW-1:0]         eps;
  logic                  seen, have_pen;
  logic signed [CW-1:0]  lo_x, lo_y, hi_x, hi_y, pen_x, pen_y;
  mode_t                 mode;
  logic                  last, cap_pen, axis;
  logic signed [CW-1:0]  px [4];
  logic signed [CW-1:0]  py [4];
  logic signed [AW-1:0]  ca, cb, cc;
  logic [MW-1:0]         mul_x;
  logic [PW-1:0]         mul_p, bb;
  logic [2*SW-1:0]       sq_rad;
  logic [RW-1:0]         sq_r;
  logic [SW-1:0]         sq_q;
  logic [NW-1:0]         dv_r, dv_d;
  logic [T_BITS-1:0]     tt;
  logic signed [CW-1:0]  w [4];
  logic signed [CW-1:0]  cx;
  logic signed [LPW-1:0] lprod;
  logic [3:0]            ls;
  logic [CNTW-1:0]       cnt;

  // Coefficients of the selected axis
  logic signed [AW-1:0] p0, p1, p2, p3, a_calc, b_calc, c_calc;
  always_comb begin
    p0 = AW'(axis ? py[0] : px[0]);
    p1 = AW'(axis ? py[1] : px[1]);
    p2 = AW'(axis ? py[2] : px[2]);
    p3 = AW'(axis ? py[3] : px[3]);
    a_calc = p3 - p0 + (p1 - p2) * AW'(3);
    b_calc = p0 + p2 - (p1 <<< 1);
    c_calc = p1 - p0;
  end

  logic [MW-1:0]   ma, mb, mc;
  logic [MW+2:0]   a3, b6;
  logic            same_sign;
  logic [DW-1:0]   disc_val;
  assign ma = ca[AW-1] ? MW'(-ca) : MW'(ca);
  assign mb = cb[AW-1] ? MW'(-cb) : MW'(cb);
  assign mc = cc[AW-1] ? MW'(-cc) : MW'(cc);
  assign a3 = (MW+3)'({ma, 1'b0}) + (MW+3)'(ma);
  assign b6 = (MW+3)'({mb, 2'b00}) + (MW+3)'({mb, 1'b0});
  assign same_sign = (ca > 0 && cc > 0) || (ca < 0 && cc < 0);
  assign disc_val = same_sign ? ({1'b0, bb} - {1'b0, mul_p}) : ({1'b0, bb} + {1'b0, mul_p});

  // Root numerator and denominator, made to have a positive denominator
  logic signed [NW-1:0] s_ext, rn_raw, rd_raw, rn, rd;
  always_comb begin
    s_ext = signed'(NW'(sq_q));
    case (cmd.sel)
      ROOT_LIN: begin
        rn_raw = -NW'(cc);
        rd_raw = NW'(cb) <<< 1;
      end
      ROOT_MINUS: begin
        rn_raw = -NW'(cb) - s_ext;
        rd_raw = NW'(ca);
      end
      default: begin
        rn_raw = -NW'(cb) + s_ext;
        rd_raw = NW'(ca);
      end
    endcase
    if (rd_raw < 0) begin
      rn = -rn_raw;
      rd = -rd_raw;
    end else begin
      rn = rn_raw;
      rd = rd_raw;
    end
  end

  // Iterative unit steps
  logic [MW:0]         mul_sum;
  logic [PW-1:0]       mul_p_step;
  logic [RW-1:0]       sq_r4, sq_trial;
  logic [NW-1:0]       dv_r2;
  logic signed [LW-1:0]  ld;
  logic signed [LPW-1:0] lround;
  assign mul_sum    = {1'b0, mul_p[PW-1:MW]} + {1'b0, mul_x};
  assign mul_p_step = mul_p[0] ? {mul_sum, mul_p[MW-1:1]} : {1'b0, mul_p[PW-1:1]};
  assign sq_r4      = {sq_r[RW-3:0], sq_rad[2*SW-1:2*SW-2]};
  assign sq_trial   = {sq_q, 2'b01};
  assign dv_r2      = {dv_r[NW-2:0], 1'b0};
  assign ld         = LW'(w[1]) - LW'(w[0]);
  assign lround     = (lprod + HALF) >>> T_BITS;

  // Point inclusion, two points a cycle
  logic                 ia_en, ib_en;
  logic signed [CW-1:0] ia_x, ia_y, ib_x, ib_y;
  logic signed [CW-1:0] t_lo_x, t_lo_y, t_hi_x, t_hi_y;
  logic signed [CW-1:0] n_lo_x, n_lo_y, n_hi_x, n_hi_y;
  always_comb begin
    ia_en = 1'b0;
    ib_en = 1'b0;
    ia_x  = px[1];
    ia_y  = py[1];
    ib_x  = px[3];
    ib_y  = py[3];
    if (cmd.op == CMD_BASE) begin
      case (mode)
        MODE_MOVE: ia_en = 1'b1;
        MODE_LINE: begin
          ia_en = cap_pen;
          ia_x  = px[0];
          ia_y  = py[0];
          ib_en = 1'b1;
          ib_x  = px[1];
          ib_y  = py[1];
        end
        MODE_CUBIC: begin
          ia_en = 1'b1;
          ia_x  = px[0];
          ia_y  = py[0];
          ib_en = 1'b1;
        end
        default: ;
      endcase
    end else if (cmd.op == CMD_INC) begin
      ia_en = 1'b1;
      ia_x  = cx;
      ia_y  = w[3];
    end
    t_lo_x = (ia_en && ia_x < lo_x) ? ia_x : lo_x;
    t_lo_y = (ia_en && ia_y < lo_y) ? ia_y : lo_y;
    t_hi_x = (ia_en && ia_x > hi_x) ? ia_x : hi_x;
    t_hi_y = (ia_en && ia_y > hi_y) ? ia_y : hi_y;
    n_lo_x = (ib_en && ib_x < t_lo_x) ? ib_x : t_lo_x;
    n_lo_y = (ib_en && ib_y < t_lo_y) ? ib_y : t_lo_y;
    n_hi_x = (ib_en && ib_x > t_hi_x) ? ib_x : t_hi_x;
    n_hi_y = (ib_en && ib_y > t_hi_y) ? ib_y : t_hi_y;
  end

  always_comb begin
    stat.mode      = mode;
    stat.last      = last;
    stat.flat_a    = a3 <= (MW+3)'(eps);
    stat.flat_b    = b6 <= (MW+3)'(eps);
    stat.disc_neg  = same_sign && (bb < mul_p);
    stat.root_ok   = (rn > 0) && (rn < rd);
    stat.cnt_done  = (cnt == '0);
    stat.drop      = DROP_MASK[ls];
    stat.lerp_last = (ls == 4'(LERP_STEPS - 1));
    stat.axis      = axis;
    stat.out_busy  = out_valid && !out_ready;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      eps       <= EW'(1);
      seen      <= 1'b0;
      have_pen  <= 1'b0;
      lo_x      <= CMAX;
      lo_y      <= CMAX;
      hi_x      <= CMIN;
      hi_y      <= CMIN;
      pen_x     <= '0;
      pen_y     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) eps <= cfg_data;
      if (cmd.op == CMD_EMIT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (ia_en || ib_en) begin
        seen <= 1'b1;
        lo_x <= n_lo_x;
        lo_y <= n_lo_y;
        hi_x <= n_hi_x;
        hi_y <= n_hi_y;
      end
      if (cmd.op == CMD_BASE) begin
        case (mode)
          MODE_MOVE, MODE_LINE: begin
            pen_x    <= px[1];
            pen_y    <= py[1];
            have_pen <= 1'b1;
          end
          MODE_CUBIC: begin
            pen_x    <= px[3];
            pen_y    <= py[3];
            have_pen <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.op == CMD_EMIT) begin
        seen      <= 1'b0;
        have_pen  <= 1'b0;
        lo_x      <= CMAX;
        lo_y      <= CMAX;
        hi_x      <= CMIN;
        hi_y      <= CMIN;
        pen_x     <= '0;
        pen_y     <= '0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        mode    <= in_mode;
        last    <= in_last;
        cap_pen <= have_pen;
        axis    <= 1'b0;
        px[0]   <= have_pen ? pen_x : '0;
        py[0]   <= have_pen ? pen_y : '0;
        px[1]   <= in_fx;
        py[1]   <= in_fy;
        px[2]   <= in_sx;
        py[2]   <= in_sy;
        px[3]   <= in_ex;
        py[3]   <= in_ey;
      end
      CMD_COEF: begin
        ca <= a_calc;
        cb <= b_calc;
        cc <= c_calc;
      end
      CMD_MUL_BB: begin
        mul_x <= mb;
        mul_p <= PW'(mb);
        cnt   <= CNTW'(MW - 1);
      end
      CMD_MUL_AC: begin
        bb    <= mul_p;
        mul_x <= ma;
        mul_p <= PW'(mc);
        cnt   <= CNTW'(MW - 1);
      end
      CMD_MUL_STEP: begin
        mul_p <= mul_p_step;
        cnt   <= cnt - 1'b1;
      end
      CMD_DISC: begin
        sq_rad <= (2*SW)'(disc_val);
        sq_r   <= '0;
        sq_q   <= '0;
        cnt    <= CNTW'(SW - 1);
      end
      CMD_SQRT_STEP: begin
        if (sq_r4 >= sq_trial) begin
          sq_r <= sq_r4 - sq_trial;
          sq_q <= {sq_q[SW-2:0], 1'b1};
        end else begin
          sq_r <= sq_r4;
          sq_q <= {sq_q[SW-2:0], 1'b0};
        end
        sq_rad <= {sq_rad[2*SW-3:0], 2'b00};
        cnt    <= cnt - 1'b1;
      end
      CMD_ROOT: begin
        dv_r <= rn;
        dv_d <= rd;
        tt   <= '0;
        cnt  <= CNTW'(T_BITS - 1);
      end
      CMD_DIV_STEP: begin
        if (dv_r2 >= dv_d) begin
          dv_r <= dv_r2 - dv_d;
          tt   <= {tt[T_BITS-2:0], 1'b1};
        end else begin
          dv_r <= dv_r2;
          tt   <= {tt[T_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      CMD_LOAD_X: begin
        w  <= px;
        ls <= '0;
      end
      CMD_LOAD_Y: begin
        cx <= w[3];
        w  <= py;
        ls <= '0;
      end
      CMD_LMUL: lprod <= LPW'(ld) * signed'(LPW'(tt));
      CMD_LADD: begin
        w[0] <= w[1];
        w[1] <= w[2];
        w[2] <= w[3];
        w[3] <= w[0] + CW'(lround);
        ls   <= ls + 1'b1;
      end
      CMD_LDROP: begin
        w[0] <= w[1];
        w[1] <= w[2];
        w[2] <= w[3];
        ls   <= ls + 1'b1;
      end
      CMD_AXIS_NEXT: axis <= 1'b1;
      CMD_EMIT: begin
        out_box_valid <= seen;
        out_left      <= seen ? lo_x : '0;
        out_top       <= seen ? lo_y : '0;
        out_width     <= seen ? CW'(hi_x - lo_x) : '0;
        out_height    <= seen ? CW'(hi_y - lo_y) : '0;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/path_bounding_box_top.sv =====
// ----------------------------------------------------------------------------
// path_bounding_box_top: bounding box of a lowered drawing path
// Move, line and cubic commands update a running box; the command marked
// last produces the box word and clears the running state.
//
// Channel   Dir  Fields
// s_axis    in   tuser: mode; tdata: first_x, first_y, second_x, second_y,
//                end_x, end_y; tlast: path_end
// m_axis    out  tuser: box_valid; tdata: box_left, box_top, box_width,
//                box_height
// cfg       in   data: flat_epsilon, always ready
//
// Move, line and ignored commands skip the curve solve; a cubic runs the
// bit-serial multiplier, square root and divider and the shared lerp unit.
// One command is worked on at a time; a waiting box word does not stop the
// next command from being taken, only the next box word from being formed.
// rst is synchronous and restores flat_epsilon to 1 and an empty box.
// ----------------------------------------------------------------------------
module path_bounding_box_top #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // first_x, first_y, second_x, second_y, end_x, end_y
  input  logic [((6*COORD_BITS+7)/8)*8-1:0]           s_tdata,
  // mode
  input  logic [1:0]                                  s_tuser,
  input  logic                                        s_tlast,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // box_left, box_top, box_width, box_height
  output logic [((4*COORD_BITS+7)/8)*8-1:0]           m_tdata,
  // box_valid
  output logic [0:0]                                  m_tuser,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [FRAC_BITS:0]                          cfg_data
);
  import pbb_pkg::*;

  localparam int CW       = COORD_BITS;
  localparam int OUT_BITS = ((4*COORD_BITS+7)/8)*8;

  pbb_cmd_t  cmd;
  pbb_stat_t stat;
  logic [CW-1:0] box_left, box_top, box_width, box_height;

  assign cfg_ready = 1'b1;
  assign m_tdata   = OUT_BITS'({box_height, box_width, box_top, box_left});

  pbb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pbb_datapath #(
    .CW (COORD_BITS),
    .FB (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_mode       (mode_t'(s_tuser)),
    .in_fx         (signed'(s_tdata[0*CW +: CW])),
    .in_fy         (signed'(s_tdata[1*CW +: CW])),
    .in_sx         (signed'(s_tdata[2*CW +: CW])),
    .in_sy         (signed'(s_tdata[3*CW +: CW])),
    .in_ex         (signed'(s_tdata[4*CW +: CW])),
    .in_ey         (signed'(s_tdata[5*CW +: CW])),
    .in_last       (s_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .out_box_valid (m_tuser[0]),
    .out_left      (box_left),
    .out_top       (box_top),
    .out_width     (box_width),
    .out_height    (box_height)
  );

endmodule

// ===== sv/pbb_checker.sv =====
// ----------------------------------------------------------------------------
// pbb_checker: port-level checks of the path bounding box block
// Watches the stream and configuration ports over time.
// ----------------------------------------------------------------------------
module pbb_checker #(
  parameter int COORD_BITS = 32
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [((4*COORD_BITS+7)/8)*8-1:0]   m_tdata,
  input logic [0:0]                          m_tuser,
  input logic                                cfg_ready
);

  // A stalled box word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("box word changed while stalled");

  // An empty path reports an all-zero box.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("empty box carries nonzero data");

  // Nothing is offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("box word offered after reset");

  // The configuration port never stalls.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port stalled");

endmodule

bind path_bounding_box_top pbb_checker #(.COORD_BITS(COORD_BITS)) u_pbb_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .cfg_ready (cfg_ready)
);
